// File: rtl/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// Shared types and codes for the stop-and-wait ARQ header engine: request
// and response words, kept link state, status, command and header type codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sawarq_pkg;

   // header length in bytes
   localparam logic [5:0] HDR_BYTES = 6'd20;

   // reset value of the receive store limit register
   localparam logic [15:0] PIPE_LIMIT_RESET = 16'd10000;

   // command codes
   localparam logic CMD_RECV = 1'b0;
   localparam logic CMD_XMIT = 1'b1;

   // special header words
   localparam logic signed [31:0] TYPE_SHUTDOWN = -32'sd2;
   localparam logic signed [31:0] TYPE_CLOSE    = -32'sd3;
   localparam logic signed [31:0] NO_DATA       = -32'sd1;

   // status codes
   localparam logic [2:0] STATUS_NONE      = 3'd0;
   localparam logic [2:0] STATUS_ACCEPTED  = 3'd1;
   localparam logic [2:0] STATUS_MALFORMED = 3'd2;
   localparam logic [2:0] STATUS_SHUTDOWN  = 3'd3;
   localparam logic [2:0] STATUS_CLOSE     = 3'd4;

   typedef struct packed {
      logic               cmd;
      logic [15:0]        dgram_len;
      logic signed [31:0] type_word;
      logic signed [31:0] ack_number;
      logic signed [31:0] ack_size;
      logic signed [31:0] data_number;
      logic signed [31:0] data_size;
      logic [15:0]        pipe_fill;
      logic [15:0]        pending_bytes;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [30:0]        release_bytes;
      logic [30:0]        deliver_bytes;
      logic signed [31:0] hdr_type;
      logic signed [31:0] hdr_ack_number;
      logic signed [31:0] hdr_ack_size;
      logic signed [31:0] hdr_data_number;
      logic signed [31:0] hdr_data_size;
      logic [15:0]        payload_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] send_seq;
      logic [31:0] recv_seq;
      logic [31:0] last_recv_size;
      logic        peer_closed;
   } link_state_type;

endpackage

`default_nettype wire

// File: rtl/sawarq_chan_if.sv
// ----------------------------------------------------------------------------
// sawarq_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface sawarq_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: rtl/sawarq_step.sv
// ----------------------------------------------------------------------------
// sawarq_step
// Combinational header step: decodes one request word against the kept link
// state and gives the response word and the next link state.
// ----------------------------------------------------------------------------
`default_nettype none

module sawarq_step #(
   parameter int TMP_BUF_BYTES = 2048
) (
   input  sawarq_pkg::req_word_type   req_word,
   input  sawarq_pkg::link_state_type state,
   input  logic [15:0]                pipe_limit,
   output sawarq_pkg::rsp_word_type   rsp_word,
   output sawarq_pkg::link_state_type state_in
);

   localparam logic [16:0] LenCap     = 17'(TMP_BUF_BYTES);
   localparam logic [15:0] PayloadCap = 16'(TMP_BUF_BYTES - 21);

   logic [16:0] len_capped;
   logic        len_short;
   logic        ack_match;
   logic        ack_positive;
   logic        data_negative;
   logic        data_none;
   logic        data_in_order;
   logic [31:0] data_end;
   logic        data_overrun;
   logic        store_full;
   logic [15:0] xmit_len;

   // cap the length at the receive buffer size and check the header fits
   assign len_capped = ({1'b0, req_word.dgram_len} > LenCap) ? LenCap
                                                            : {1'b0, req_word.dgram_len};
   assign len_short  = len_capped < {11'd0, sawarq_pkg::HDR_BYTES};

   // ack and data qualifiers
   assign ack_match     = req_word.ack_number == state.send_seq;
   assign ack_positive  = !req_word.ack_size[31] && (req_word.ack_size != '0);
   assign data_negative = req_word.data_number[31] || req_word.data_size[31];
   assign data_none     = (req_word.data_number == sawarq_pkg::NO_DATA) &&
                          (req_word.data_size == sawarq_pkg::NO_DATA);
   assign data_in_order = (req_word.data_number == state.recv_seq) &&
                          (req_word.data_size != '0);
   assign data_end      = {1'b0, req_word.data_size[30:0]} +
                          {26'd0, sawarq_pkg::HDR_BYTES};
   assign data_overrun  = {15'd0, len_capped} < data_end;
   assign store_full    = req_word.pipe_fill >= pipe_limit;

   // payload length for transmit, capped to the staging buffer
   assign xmit_len = (req_word.pending_bytes < PayloadCap) ? req_word.pending_bytes
                                                           : PayloadCap;

   always_comb begin
      rsp_word = '0;
      state_in = state;
      if (req_word.cmd == sawarq_pkg::CMD_XMIT) begin
         // build the transmit header from the kept sequence numbers
         rsp_word.hdr_type       = req_word.type_word;
         rsp_word.hdr_ack_number = state.recv_seq - 32'd1;
         rsp_word.hdr_ack_size   = state.last_recv_size;
         if (req_word.pending_bytes != '0) begin
            rsp_word.hdr_data_number = state.send_seq;
            rsp_word.hdr_data_size   = {16'd0, xmit_len};
            rsp_word.payload_bytes   = xmit_len;
         end else begin
            rsp_word.hdr_data_number = sawarq_pkg::NO_DATA;
            rsp_word.hdr_data_size   = sawarq_pkg::NO_DATA;
         end
      end else if (len_short) begin
         rsp_word.status = sawarq_pkg::STATUS_MALFORMED;
      end else if (req_word.type_word == sawarq_pkg::TYPE_SHUTDOWN) begin
         rsp_word.status = sawarq_pkg::STATUS_SHUTDOWN;
      end else if (req_word.type_word == sawarq_pkg::TYPE_CLOSE) begin
         rsp_word.status      = sawarq_pkg::STATUS_CLOSE;
         state_in.peer_closed = 1'b1;
      end else begin
         // release acknowledged send bytes
         if (ack_match) begin
            rsp_word.release_bytes = ack_positive ? req_word.ack_size[30:0] : '0;
            state_in.send_seq      = state.send_seq + 32'd1;
         end
         // take in-order data
         if (data_negative) begin
            rsp_word.status = data_none ? sawarq_pkg::STATUS_NONE
                                        : sawarq_pkg::STATUS_MALFORMED;
         end else if (data_in_order) begin
            if (data_overrun) begin
               rsp_word.status = sawarq_pkg::STATUS_MALFORMED;
            end else if (store_full) begin
               rsp_word.status = sawarq_pkg::STATUS_NONE;
            end else begin
               rsp_word.status         = sawarq_pkg::STATUS_ACCEPTED;
               rsp_word.deliver_bytes  = req_word.data_size[30:0];
               state_in.recv_seq       = state.recv_seq + 32'd1;
               state_in.last_recv_size = req_word.data_size;
            end
         end else begin
            rsp_word.status = sawarq_pkg::STATUS_NONE;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/stop_and_wait_arq_endpoint_core.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_endpoint_core
// Header engine for a stop-and-wait ARQ link: checks received headers,
// releases acknowledged bytes, accepts in-order data and builds transmit
// headers.
//
//   Port     Dir   Kind          Word
//   req_if   in    valid/ready   sawarq_pkg::req_word_type
//   rsp_if   out   valid/ready   sawarq_pkg::rsp_word_type
//   csr_*    in    write only    pipe_limit, 16 bits
//
// One word per cycle while rsp_if is not stalled. A word is evaluated against
// the link state while it sits in the input register, and its response is
// loaded into the output register as the word moves on; from there it is
// offered on rsp_if. Link state updates as a word moves into the output
// register, so the next word sees it. Reset clears link state and sets
// pipe_limit to 10000. A stalled response holds both registers; the input
// takes a word whenever the input register is empty or moving on.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_arq_endpoint_core #(
   parameter int TMP_BUF_BYTES = 2048
) (
   input  logic               clock,
   input  logic               reset,
   sawarq_chan_if.sink        req_if,
   sawarq_chan_if.source      rsp_if,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   sawarq_pkg::req_word_type   in_word_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   sawarq_pkg::rsp_word_type   out_word_ff;
   sawarq_pkg::link_state_type state_ff;
   sawarq_pkg::link_state_type state_in;
   logic [15:0]                pipe_limit_ff;
   logic [15:0]                pipe_limit_in;
   sawarq_pkg::rsp_word_type   step_rsp;
   logic                       advance;
   logic                       take;

   // move a word on when the output register is free or being drained
   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign take    = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_word_ff;

   assign in_valid_in   = take || (in_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_if.ready);
   assign pipe_limit_in = csr_wr_en ? csr_wr_data : pipe_limit_ff;

   sawarq_step #(
      .TMP_BUF_BYTES (TMP_BUF_BYTES)
   ) u_step (
      .req_word   (in_word_ff),
      .state      (state_ff),
      .pipe_limit (pipe_limit_ff),
      .rsp_word   (step_rsp),
      .state_in   (state_in)
   );

   // control and link state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         pipe_limit_ff <= sawarq_pkg::PIPE_LIMIT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         pipe_limit_ff <= pipe_limit_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= req_if.data;
      end
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

   // a close header marks the peer closed
   assert property (@(posedge clock) disable iff (reset)
      advance && (step_rsp.status == sawarq_pkg::STATUS_CLOSE) |=> state_ff.peer_closed)
      else $error("close header did not mark peer closed");

   // link state holds while no word moves on
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("link state changed without a word");

   // a transmit payload always matches the header data size
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_word_ff.payload_bytes != '0) |->
         (out_word_ff.hdr_data_size == {16'd0, out_word_ff.payload_bytes}))
      else $error("payload size disagrees with header");

endmodule

`default_nettype wire

// File: bench/stop_and_wait_arq_endpoint_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_endpoint_core_tb
// Self-checking bench for the ARQ header engine. Request words go in over the
// req channel, and a scoreboard keeps its own copy of the link state and the
// pipe_limit register. It works out the response each accepted word must give
// and matches the responses field by field, in order. Stimulus is a directed
// set of corner cases and then mostly well-formed exchanges that track the
// live sequence numbers. Both channels idle at random, in three patterns, and
// pipe_limit is rewritten between segments whenever the engine is empty.
// ----------------------------------------------------------------------------

module stop_and_wait_arq_endpoint_core_tb;

   localparam int TMP_BUF_BYTES = 2048;
   localparam int XMIT_CAP      = TMP_BUF_BYTES - 21;
   localparam int MAX_CYCLES    = 200000;
   localparam int SEGMENT_WORDS = 300;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow link state, expected responses, field compare
   // -------------------------------------------------------------------------
   class link_header_checker;
      bit [15:0]                pipe_limit;
      bit [31:0]                send_seq;
      bit [31:0]                recv_seq;
      bit [31:0]                last_size;
      bit                       peer_closed;
      sawarq_pkg::rsp_word_type awaited_rsp[$];
      int                       errors;
      int                       requests;
      int                       responses;
      int                       taken;
      int                       releases;
      int                       closes;
      int                       malformed;

      function new();
         pipe_limit  = sawarq_pkg::PIPE_LIMIT_RESET;
         send_seq    = '0;
         recv_seq    = '0;
         last_size   = '0;
         peer_closed = 1'b0;
         errors      = 0;
         requests    = 0;
         responses   = 0;
         taken       = 0;
         releases    = 0;
         closes      = 0;
         malformed   = 0;
      endfunction

      function void set_limit(bit [15:0] value);
         pipe_limit = value;
      endfunction

      function int outstanding();
         return awaited_rsp.size();
      endfunction

      // Work out the response to one word and advance the shadow state
      function sawarq_pkg::rsp_word_type header_outcome(sawarq_pkg::req_word_type w);
         sawarq_pkg::rsp_word_type r;
         longint                   len;
         longint                   acks;
         longint                   dnum;
         longint                   dsz;
         int                       n;
         r = '0;
         if (w.cmd == sawarq_pkg::CMD_XMIT) begin
            r.hdr_type       = w.type_word;
            r.hdr_ack_number = recv_seq - 32'd1;
            r.hdr_ack_size   = last_size;
            if (w.pending_bytes != 16'd0) begin
               n = (int'(w.pending_bytes) < XMIT_CAP) ? int'(w.pending_bytes) : XMIT_CAP;
               r.hdr_data_number = send_seq;
               r.hdr_data_size   = n;
               r.payload_bytes   = n[15:0];
            end else begin
               r.hdr_data_number = sawarq_pkg::NO_DATA;
               r.hdr_data_size   = sawarq_pkg::NO_DATA;
               r.payload_bytes   = '0;
            end
            return r;
         end

         len  = longint'(w.dgram_len);
         acks = longint'($signed(w.ack_size));
         dnum = longint'($signed(w.data_number));
         dsz  = longint'($signed(w.data_size));
         if (len > TMP_BUF_BYTES)
            len = TMP_BUF_BYTES;

         // length and shutdown end the word with no state change; close only marks the peer closed
         if (len < longint'(sawarq_pkg::HDR_BYTES)) begin
            r.status = sawarq_pkg::STATUS_MALFORMED;
            return r;
         end
         if ($signed(w.type_word) == sawarq_pkg::TYPE_SHUTDOWN) begin
            r.status = sawarq_pkg::STATUS_SHUTDOWN;
            return r;
         end
         if ($signed(w.type_word) == sawarq_pkg::TYPE_CLOSE) begin
            peer_closed = 1'b1;
            r.status    = sawarq_pkg::STATUS_CLOSE;
            return r;
         end

         // a matching ack releases bytes even if the data part is bad
         if (w.ack_number == send_seq) begin
            r.release_bytes = (acks > 0) ? w.ack_size[30:0] : '0;
            send_seq        = send_seq + 32'd1;
         end

         if (dnum < 0 || dsz < 0) begin
            r.status = (dnum == -1 && dsz == -1) ? sawarq_pkg::STATUS_NONE
                                                 : sawarq_pkg::STATUS_MALFORMED;
            return r;
         end

         r.status = sawarq_pkg::STATUS_NONE;
         if (w.data_number == recv_seq && dsz > 0) begin
            if (len < longint'(sawarq_pkg::HDR_BYTES) + dsz) begin
               r.status = sawarq_pkg::STATUS_MALFORMED;
            end else if (w.pipe_fill >= pipe_limit) begin
               r.status = sawarq_pkg::STATUS_NONE;
            end else begin
               recv_seq        = recv_seq + 32'd1;
               last_size       = w.data_size;
               r.status        = sawarq_pkg::STATUS_ACCEPTED;
               r.deliver_bytes = w.data_size[30:0];
            end
         end
         return r;
      endfunction

      function void note_request(sawarq_pkg::req_word_type w);
         sawarq_pkg::rsp_word_type r;
         r = header_outcome(w);
         requests++;
         if (r.status == sawarq_pkg::STATUS_ACCEPTED)  taken++;
         if (r.status == sawarq_pkg::STATUS_CLOSE)     closes++;
         if (r.status == sawarq_pkg::STATUS_MALFORMED) malformed++;
         if (r.release_bytes != 0)                     releases++;
         awaited_rsp.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch on response %0d, expected 0x%0h actual 0x%0h",
                     $time, name, responses, want, got);
         end
      endfunction

      function void check_response(sawarq_pkg::rsp_word_type got);
         sawarq_pkg::rsp_word_type want;
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t ns: response with none expected, expected nothing actual 0x%0h",
                     $time, got);
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status",          want.status,          got.status);
         compare_field("release_bytes",   want.release_bytes,   got.release_bytes);
         compare_field("deliver_bytes",   want.deliver_bytes,   got.deliver_bytes);
         compare_field("hdr_type",        want.hdr_type,        got.hdr_type);
         compare_field("hdr_ack_number",  want.hdr_ack_number,  got.hdr_ack_number);
         compare_field("hdr_ack_size",    want.hdr_ack_size,    got.hdr_ack_size);
         compare_field("hdr_data_number", want.hdr_data_number, got.hdr_data_number);
         compare_field("hdr_data_size",   want.hdr_data_size,   got.hdr_data_size);
         compare_field("payload_bytes",   want.payload_bytes,   got.payload_bytes);
         responses++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          send_idle_pct;
   int          recv_stall_pct;

   sawarq_chan_if #(.payload_type(sawarq_pkg::req_word_type)) req_chan ();
   sawarq_chan_if #(.payload_type(sawarq_pkg::rsp_word_type)) rsp_chan ();

   link_header_checker sb;

   stop_and_wait_arq_endpoint_core #(
      .TMP_BUF_BYTES (TMP_BUF_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the response side at the current rate
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check every response word that moves
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.data);
   end

   // Abort a hung run
   initial begin
      repeat (MAX_CYCLES) @(posedge clock);
      $display("FAIL stop_and_wait_arq_endpoint_core");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Word builders
   // -------------------------------------------------------------------------
   function automatic sawarq_pkg::req_word_type recv_word(logic [15:0] len,
                                                          logic signed [31:0] kind,
                                                          logic [31:0] ackn,
                                                          logic signed [31:0] acks,
                                                          logic [31:0] dnum,
                                                          logic signed [31:0] dsz,
                                                          logic [15:0] fill);
      sawarq_pkg::req_word_type w;
      w.cmd           = sawarq_pkg::CMD_RECV;
      w.dgram_len     = len;
      w.type_word     = kind;
      w.ack_number    = ackn;
      w.ack_size      = acks;
      w.data_number   = dnum;
      w.data_size     = dsz;
      w.pipe_fill     = fill;
      w.pending_bytes = 16'($urandom);
      return w;
   endfunction

   function automatic sawarq_pkg::req_word_type xmit_word(logic signed [31:0] kind,
                                                          logic [15:0] pend);
      sawarq_pkg::req_word_type w;
      w.cmd           = sawarq_pkg::CMD_XMIT;
      w.dgram_len     = 16'($urandom);
      w.type_word     = kind;
      w.ack_number    = $urandom;
      w.ack_size      = $urandom;
      w.data_number   = $urandom;
      w.data_size     = $urandom;
      w.pipe_fill     = 16'($urandom);
      w.pending_bytes = pend;
      return w;
   endfunction

   // Receive store fill near the current limit, mostly below it
   function automatic logic [15:0] fill_near_limit();
      int lim;
      lim = int'(sb.pipe_limit);
      case ($urandom_range(3)) inside
         [0:1]:   return (lim == 0) ? 16'd0 : 16'($urandom_range(lim - 1));
         2:       return (lim == 0) ? 16'd0 : 16'(lim - int'($urandom_range(1)));
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly well-formed exchanges against the live sequence numbers, some noise
   function automatic sawarq_pkg::req_word_type random_header();
      sawarq_pkg::req_word_type w;
      int                       pick;
      logic signed [31:0]       kind;
      logic [31:0]              ackn;
      logic signed [31:0]       acks;
      logic signed [31:0]       dsz;
      logic [15:0]              pend;
      int                       len;
      pick = $urandom_range(99);
      if (pick < 14) begin
         kind = $urandom_range(1) ? 32'($urandom_range(3)) : 32'($urandom);
         case ($urandom_range(3))
            0:       pend = 16'd0;
            1:       pend = 16'($urandom_range(1, 2100));
            2:       pend = 16'($urandom_range(XMIT_CAP - 1, XMIT_CAP + 1));
            default: pend = 16'($urandom);
         endcase
         return xmit_word(kind, pend);
      end
      if (pick < 82) begin
         kind = $urandom_range(1) ? 32'sd0 : 32'($urandom);
         if (kind == sawarq_pkg::TYPE_SHUTDOWN || kind == sawarq_pkg::TYPE_CLOSE)
            kind = 32'sd0;
         ackn = ($urandom_range(9) < 8) ? sb.send_seq : sb.send_seq + 32'($urandom_range(1, 3));
         acks = ($urandom_range(9) < 8) ? 32'($urandom_range(2028)) : 32'($urandom);
         if ($urandom_range(9) < 7) begin
            dsz = ($urandom_range(3) == 0) ? 32'($urandom_range(1, 2028))
                                           : 32'($urandom_range(1, 64));
            len = 20 + int'(dsz);
            if ($urandom_range(3) == 0)
               len = len + int'($urandom_range(50));
            else if ($urandom_range(9) == 0)
               len = len - 1;
            w = recv_word(16'(len), kind, ackn, acks,
                          ($urandom_range(9) < 9) ? sb.recv_seq : sb.recv_seq - 32'd1,
                          dsz, fill_near_limit());
         end else begin
            w = recv_word(16'($urandom_range(20, 2100)), kind, ackn, acks,
                          sawarq_pkg::NO_DATA, sawarq_pkg::NO_DATA, fill_near_limit());
         end
         return w;
      end
      // noise: random words, short lengths, shutdown and close
      w = recv_word(16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                    32'($urandom), 32'($urandom), 16'($urandom));
      case ($urandom_range(5))
         0: w.type_word = sawarq_pkg::TYPE_SHUTDOWN;
         1: w.type_word = sawarq_pkg::TYPE_CLOSE;
         2: w.dgram_len = 16'($urandom_range(25));
         3: w.data_number = $urandom_range(1) ? sawarq_pkg::NO_DATA : 32'(sb.recv_seq);
         4: w.data_size = $urandom_range(1) ? sawarq_pkg::NO_DATA
                                            : 32'($urandom_range(1, 3000));
         default: ;
      endcase
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   // Offer one word, idling first at the current rate, and hold until taken
   task automatic send_req(input sawarq_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do
         @(posedge clock);
      while (!req_chan.ready);
      sb.note_request(w);
   endtask

   // Wait out every expected response plus the pipeline depth
   task automatic drain();
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(value);
   endtask

   // One segment: new limit on an idle engine, then random words
   task automatic run_segment(input logic [15:0] limit, input int words, input bit mid_pause);
      write_limit(limit);
      for (int i = 0; i < words; i++) begin
         if (mid_pause && i == words / 2) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            drain();
         end
         send_req(random_header());
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb             = new();
      send_idle_pct  = 11;
      recv_stall_pct = 59;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners under the reset limit
      send_req(xmit_word(32'sd0, 16'd0));
      send_req(xmit_word(32'sh7fffffff, 16'd1));
      send_req(xmit_word(32'sh80000000, 16'hffff));
      send_req(xmit_word(-32'sd1, 16'(XMIT_CAP)));
      send_req(xmit_word(32'sd1, 16'(XMIT_CAP + 1)));
      send_req(recv_word(16'd19, 32'sd0, sb.send_seq, 32'sd5, 32'd0, 32'sd5, 16'd0));
      send_req(recv_word(16'd0, 32'sd0, sb.send_seq, 32'sd5, 32'd0, 32'sd5, 16'd0));
      send_req(recv_word(16'd20, sawarq_pkg::TYPE_SHUTDOWN, sb.send_seq, 32'sd5, 32'd0,
                         32'sd5, 16'd0));
      send_req(recv_word(16'd20, sawarq_pkg::TYPE_CLOSE, sb.send_seq, 32'sd5, 32'd0,
                         32'sd5, 16'd0));
      send_req(recv_word(16'd20, 32'sd0, sb.send_seq, 32'sd100, sawarq_pkg::NO_DATA,
                         sawarq_pkg::NO_DATA, 16'd0));
      send_req(recv_word(16'd40, 32'sd0, sb.send_seq, -32'sd5, sawarq_pkg::NO_DATA,
                         32'sd5, 16'd0));
      send_req(recv_word(16'd40, 32'sd0, sb.send_seq + 32'd7, 32'sd50, -32'sd5,
                         sawarq_pkg::NO_DATA, 16'd0));
      send_req(recv_word(16'd30, 32'sd1, sb.send_seq, 32'sh7fffffff, sb.recv_seq, 32'sd10,
                         16'd0));
      send_req(recv_word(16'hffff, 32'sd0, sb.send_seq, 32'sd0, sb.recv_seq, 32'sd2028,
                         16'd9999));
      send_req(recv_word(16'hffff, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq, 32'sd2029,
                         16'd0));
      send_req(recv_word(16'd100, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq + 32'd1, 32'sd5,
                         16'd0));
      send_req(recv_word(16'd100, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq, 32'sd0, 16'd0));
      send_req(recv_word(16'd25, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq, 32'sd5, 16'd10000));
      send_req(recv_word(16'd25, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq, 32'sd5, 16'hffff));
      send_req(recv_word(16'hffff, 32'sd0, sb.send_seq, 32'sd1, sb.recv_seq, 32'sh7fffffff,
                         16'd0));
      send_req(recv_word(16'd100, 32'sd0, sb.send_seq, 32'sd1, 32'h80000000,
                         sawarq_pkg::NO_DATA, 16'd0));
      send_req(recv_word(16'd25, 32'sh7fffffff, sb.send_seq, 32'sd2, sb.recv_seq, 32'sd5,
                         16'd0));
      send_req(xmit_word(32'sd7, 16'd100));
      req_chan.valid <= 1'b0;
      @(posedge clock);
      drain();

      // Sender mostly busy, receiver stalling often
      run_segment(16'd0, SEGMENT_WORDS, 1'b0);
      run_segment(16'hffff, SEGMENT_WORDS, 1'b1);

      // Sender idling often, receiver mostly ready
      send_idle_pct  = 59;
      recv_stall_pct = 11;
      run_segment(16'($urandom), SEGMENT_WORDS, 1'b0);
      run_segment(16'd1, SEGMENT_WORDS, 1'b0);

      // Back to back on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_segment(16'd2048, SEGMENT_WORDS, 1'b0);
      run_segment(sawarq_pkg::PIPE_LIMIT_RESET, SEGMENT_WORDS, 1'b0);

      $display("Checked %0d responses to %0d request words: %0d data words taken, %0d releases,",
               sb.responses, sb.requests, sb.taken, sb.releases);
      $display("%0d closes, %0d malformed, over pipe_limit 0 to 65535 and three idle patterns.",
               sb.closes, sb.malformed);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("PASS stop_and_wait_arq_endpoint_core");
      end else begin
         $display("FAIL stop_and_wait_arq_endpoint_core");
      end
      $finish;
   end

endmodule

// File: stop_and_wait_arq_endpoint_core.f
rtl/sawarq_pkg.sv
rtl/sawarq_chan_if.sv
rtl/sawarq_step.sv
rtl/stop_and_wait_arq_endpoint_core.sv
bench/stop_and_wait_arq_endpoint_core_tb.sv
